### rtl/npr_pkg.sv
package npr_pkg;

  localparam int unsigned CFG_W  = 5;
  localparam int unsigned REQ_W  = 4;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned STAT_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic MODE_POST  = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  localparam logic REG_CAPACITY     = 1'b0;
  localparam logic REG_SOURCE_COUNT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_POSTED    = 3'd0,
    STAT_WAITING   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_READY = 3'd3,
    STAT_SERVED    = 3'd4
  } status_e;

endpackage

### rtl/npr_ram.sv
module npr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 25
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/nearest_position_request_table.sv
// Channel  | Direction | Signals
// ---------+-----------+------------------------------------------------------------
// request  | in        | in_valid_i/in_ready_o: mode_i requester_i position_i final_request_i
// result   | out       | out_valid_o/out_ready_i: status_o served_requester_o
//          |           |   served_position_o served_final_o occupancy_o
// config   | in/out    | psel penable pwrite paddr pwdata / prdata pready (APB style)
//
// Sweeps: one transfer per item. A refused post or an early serve takes a single sweep of the
//   entry memory; an accepted post or a granted serve takes two sweeps (search, then age update).
//   The single read port of the entry memory sets the length of each sweep.
// Reset: valid bits, counters and limits clear at once; the entry memory needs no clearing pass.
// Stalls: a finished result waits in the output register while the next item is accepted;
//   the sequencer holds in its finish step only if the previous result has not been taken yet.
module nearest_position_request_table import npr_pkg::*; #(
  parameter int unsigned SLOTS         = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [REQ_W-1:0]    requester_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                final_request_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STAT_W-1:0]   status_o,
  output logic [REQ_W-1:0]    served_requester_o,
  output logic [POS_W-1:0]    served_position_o,
  output logic                served_final_o,
  output logic [CFG_W-1:0]    occupancy_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned MW = (NW > CFG_W) ? NW : CFG_W;
  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned DW = PB + 1;
  localparam int unsigned EW = REQ_W + PB + 1 + IW;

  // One memory word per slot; age is the rank among pending entries, 0 for the newest.
  typedef struct packed {
    logic [REQ_W-1:0] src;
    logic [PB-1:0]    pos;
    logic             fin;
    logic [IW-1:0]    age;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_FINISH
  } state_e;

  function automatic logic [NW-1:0] limit_f(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] src);
    logic [CFG_W-1:0] m;
    logic [31:0]      m32;
    m   = (cap < src) ? cap : src;
    m32 = 32'(m);
    if (m32 > SLOTS) begin
      m32 = SLOTS;
    end
    return m32[NW-1:0];
  endfunction

  // Sequencer and sweep pointers
  state_e            state_q;
  logic [NW-1:0]     cnt_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;

  // Item being worked on
  logic              mode_q;
  logic [REQ_W-1:0]  req_q;
  logic [PB-1:0]     pos_q;
  logic              fin_q;

  // Search results of the first sweep
  logic              dup_q;
  logic              free_found_q;
  logic [IW-1:0]     free_idx_q;
  logic              best_found_q;
  logic [DW-1:0]     best_d_q;
  logic [IW-1:0]     best_idx_q;
  logic [IW-1:0]     best_age_q;
  logic [REQ_W-1:0]  best_src_q;
  logic [PB-1:0]     best_pos_q;
  logic              best_fin_q;

  // Table state
  logic [SLOTS-1:0]  valid_q;
  logic [NW-1:0]     pending_q;
  logic signed [PB:0] last_q;
  logic [CFG_W-1:0]  active_q;
  logic [NW-1:0]     limit_q;
  logic [CFG_W-1:0]  cap_q;
  logic [CFG_W-1:0]  src_q;

  // Result waiting for the output register
  status_e           res_status_q;
  logic [REQ_W-1:0]  res_src_q;
  logic [PB-1:0]     res_pos_q;
  logic              res_fin_q;

  // Output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [REQ_W-1:0]  out_src_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_fin_q;
  logic [CFG_W-1:0]  out_occ_q;

  // Memory port signals
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;
  entry_t            rd_entry;
  logic              wr_en;
  entry_t            wr_entry;

  logic              last_proc;
  logic              cur_valid;
  logic signed [PB+1:0] diff;
  logic signed [PB+1:0] diff_neg;
  logic [DW-1:0]     seek_gap;
  logic              better;
  logic              cfg_we;
  logic [31:0]       pos_in32;
  logic [31:0]       best_pos32;
  logic [CFG_W-1:0]  act_dec;
  logic [CFG_W-1:0]  new_cap;
  logic [CFG_W-1:0]  new_src;

  assign in_ready_o = (state_q == S_IDLE);
  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite;
  assign prdata     = (paddr[2] == REG_SOURCE_COUNT) ? 32'(src_q) : 32'(cap_q);
  assign new_cap    = (paddr[2] == REG_CAPACITY) ? pwdata[CFG_W-1:0] : cap_q;
  assign new_src    = (paddr[2] == REG_SOURCE_COUNT) ? pwdata[CFG_W-1:0] : src_q;

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign served_requester_o = out_src_q;
  assign served_position_o  = out_pos_q;
  assign served_final_o     = out_fin_q;
  assign occupancy_o        = out_occ_q;

  assign pos_in32   = 32'(position_i);
  assign best_pos32 = 32'(res_pos_q);

  // Issue one read a cycle during a sweep; data comes back in the next cycle.
  assign rd_en     = ((state_q == S_SCAN) || (state_q == S_UPDATE)) && (cnt_q < NW'(SLOTS));
  assign rd_addr   = cnt_q[IW-1:0];
  assign rd_entry  = entry_t'(rd_data);
  assign last_proc = rd_vld_q && (rd_idx_q == IW'(SLOTS - 1));
  assign cur_valid = valid_q[rd_idx_q];

  // Exact distance to the last served position, which starts at minus one.
  assign diff     = {last_q[PB], last_q} - $signed({2'b00, rd_entry.pos});
  assign diff_neg = -diff;
  assign seek_gap = diff[PB+1] ? diff_neg[DW-1:0] : diff[DW-1:0];
  assign better   = !best_found_q || (seek_gap < best_d_q) ||
                    ((seek_gap == best_d_q) && (rd_entry.age > best_age_q));

  assign act_dec = (best_fin_q && (active_q != '0)) ? active_q - 1'b1 : active_q;

  // Write back during the update sweep: the new entry lands in its free slot, others re-rank.
  always_comb begin
    wr_en    = 1'b0;
    wr_entry = rd_entry;
    if ((state_q == S_UPDATE) && rd_vld_q) begin
      if (mode_q == MODE_POST) begin
        if (rd_idx_q == free_idx_q) begin
          wr_en        = 1'b1;
          wr_entry.src = req_q;
          wr_entry.pos = pos_q;
          wr_entry.fin = fin_q;
          wr_entry.age = '0;
        end else if (cur_valid) begin
          wr_en        = 1'b1;
          wr_entry.age = rd_entry.age + 1'b1;
        end
      end else if (cur_valid && (rd_entry.age > best_age_q)) begin
        wr_en        = 1'b1;
        wr_entry.age = rd_entry.age - 1'b1;
      end
    end
  end

  npr_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (rd_idx_q),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      mode_q       <= MODE_POST;
      req_q        <= '0;
      pos_q        <= '0;
      fin_q        <= 1'b0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_found_q <= 1'b0;
      best_d_q     <= '0;
      best_idx_q   <= '0;
      best_age_q   <= '0;
      best_src_q   <= '0;
      best_pos_q   <= '0;
      best_fin_q   <= 1'b0;
      valid_q      <= '0;
      pending_q    <= '0;
      last_q       <= '1;
      active_q     <= CFG_RESET;
      limit_q      <= limit_f(CFG_RESET, CFG_RESET);
      cap_q        <= CFG_RESET;
      src_q        <= CFG_RESET;
      res_status_q <= STAT_POSTED;
      res_src_q    <= '0;
      res_pos_q    <= '0;
      res_fin_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_POSTED;
      out_src_q    <= '0;
      out_pos_q    <= '0;
      out_fin_q    <= 1'b0;
      out_occ_q    <= '0;
    end else begin
      // Drop the result once transferred, unless the finish step reloads it.
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      // Register writes reload the limits and keep pending entries.
      if (cfg_we) begin
        cap_q    <= new_cap;
        src_q    <= new_src;
        active_q <= new_src;
        limit_q  <= limit_f(new_cap, new_src);
      end

      // Advance the sweep pointer.
      if (rd_en) begin
        cnt_q    <= cnt_q + 1'b1;
        rd_vld_q <= 1'b1;
        rd_idx_q <= rd_addr;
      end else begin
        rd_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q       <= mode_i;
            req_q        <= requester_i;
            pos_q        <= pos_in32[PB-1:0];
            fin_q        <= final_request_i;
            dup_q        <= 1'b0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            cnt_q        <= '0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld_q) begin
            if (mode_q == MODE_POST) begin
              if (cur_valid && (rd_entry.src == req_q)) begin
                dup_q <= 1'b1;
              end
              if (!cur_valid && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= rd_idx_q;
              end
            end else if (cur_valid && better) begin
              best_found_q <= 1'b1;
              best_d_q     <= seek_gap;
              best_idx_q   <= rd_idx_q;
              best_age_q   <= rd_entry.age;
              best_src_q   <= rd_entry.src;
              best_pos_q   <= rd_entry.pos;
              best_fin_q   <= rd_entry.fin;
            end
          end
          if (last_proc) begin
            cnt_q   <= '0;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_src_q <= '0;
          res_pos_q <= '0;
          res_fin_q <= 1'b0;
          state_q   <= S_FINISH;
          if (mode_q == MODE_POST) begin
            if (dup_q) begin
              res_status_q <= STAT_WAITING;
            end else if ((pending_q >= limit_q) || !free_found_q) begin
              res_status_q <= STAT_FULL;
            end else begin
              valid_q[free_idx_q] <= 1'b1;
              pending_q           <= pending_q + 1'b1;
              res_status_q        <= STAT_POSTED;
              state_q             <= S_UPDATE;
            end
          end else begin
            if ((limit_q == '0) || (pending_q < limit_q) || !best_found_q) begin
              res_status_q <= STAT_NOT_READY;
            end else begin
              valid_q[best_idx_q] <= 1'b0;
              pending_q           <= pending_q - 1'b1;
              last_q              <= $signed({1'b0, best_pos_q});
              active_q            <= act_dec;
              if (MW'(act_dec) < MW'(limit_q)) begin
                limit_q <= NW'(act_dec);
              end
              res_status_q <= STAT_SERVED;
              res_src_q    <= best_src_q;
              res_pos_q    <= best_pos_q;
              res_fin_q    <= best_fin_q;
              state_q      <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (last_proc) begin
            cnt_q   <= '0;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_src_q    <= res_src_q;
            out_pos_q    <= best_pos32[POS_W-1:0];
            out_fin_q    <= res_fin_q;
            out_occ_q    <= CFG_W'(pending_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Pending count tracks the valid bits whenever no item is in flight.
  a_pending_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_q) == pending_q))
    else $error("pending count differs from number of valid entries");

  // A write back never targets the slot being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (rd_idx_q != rd_addr))
    else $error("entry memory read and write collide");

  // Occupancy never exceeds the table size.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= NW'(SLOTS))
    else $error("pending count above table size");

  // A served result leaves its entry retired.
  a_served_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && (mode_q == MODE_SERVE) && best_found_q &&
     (limit_q != '0) && (pending_q >= limit_q)) |=> !valid_q[best_idx_q])
    else $error("served entry still valid");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import npr_pkg::*;

  // Slot count of the instance under test (the block's default).
  localparam int SLOT_COUNT = 16;
  // Cycles without any transfer before the run is declared hung. This covers
  // the receiver hold-off plus the processing of the items in flight.
  localparam int WATCHDOG_LIMIT = 2000;
  // Rest after the last result before a register write or the end of the
  // run: comfortably above the time that a two-sweep item takes.
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    status_e           status;
    logic [REQ_W-1:0]  requester;
    logic [POS_W-1:0]  position;
    logic              final_mark;
    logic [CFG_W-1:0]  occupancy;
  } table_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic [REQ_W-1:0]   requester_i;
  logic [POS_W-1:0]   position_i;
  logic               final_request_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [STAT_W-1:0]  status_o;
  logic [REQ_W-1:0]   served_requester_o;
  logic [POS_W-1:0]   served_position_o;
  logic               served_final_o;
  logic [CFG_W-1:0]   occupancy_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  nearest_position_request_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .requester_i        (requester_i),
    .position_i         (position_i),
    .final_request_i    (final_request_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .served_requester_o (served_requester_o),
    .served_position_o  (served_position_o),
    .served_final_o     (served_final_o),
    .occupancy_o        (occupancy_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // 2 ns clock.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the request table, updated once per accepted request.
  // ---------------------------------------------------------------------------
  bit               slot_used  [SLOT_COUNT];
  logic [REQ_W-1:0] slot_source[SLOT_COUNT];
  logic [POS_W-1:0] slot_pos   [SLOT_COUNT];
  logic             slot_final [SLOT_COUNT];
  int               slot_rank  [SLOT_COUNT];  // 0 newest, larger is older
  int               table_count;
  int               last_pos;                 // -1 until the first serve
  int               live_sources;
  int               table_limit;
  int               capacity_reg;
  int               source_count_reg;

  table_result_t    expected_results[$];
  int               errors;

  // Handshake between the test sequence and the receiver process.
  bit               quiet;          // suppress random idling on both sides
  bit               stall_request;  // ask the receiver for a long hold-off
  int               stall_left;
  int               idle_cycles;

  // Recompute the limits from the registers; pending entries stay.
  function automatic void reload_limits();
    int lim;
    lim = (capacity_reg < source_count_reg) ? capacity_reg : source_count_reg;
    if (lim > SLOT_COUNT) lim = SLOT_COUNT;
    live_sources = source_count_reg;
    table_limit  = lim;
  endfunction

  function automatic void reset_table_shadow();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_used[i]   = 1'b0;
      slot_source[i] = '0;
      slot_pos[i]    = '0;
      slot_final[i]  = 1'b0;
      slot_rank[i]   = 0;
    end
    table_count      = 0;
    last_pos         = -1;
    capacity_reg     = CFG_RESET;
    source_count_reg = CFG_RESET;
    reload_limits();
  endfunction

  // Work out the result of one accepted request and queue it.
  function automatic void predict_table_step(logic mode, logic [REQ_W-1:0] req,
                                             logic [POS_W-1:0] pos, logic fin);
    table_result_t res;
    int free_slot;
    int best;
    int best_gap;
    int gap;
    res.status     = STAT_NOT_READY;
    res.requester  = '0;
    res.position   = '0;
    res.final_mark = 1'b0;
    free_slot      = -1;
    best           = -1;
    best_gap       = 0;

    if (mode == MODE_POST) begin
      res.status = STAT_POSTED;
      // A waiting source is refused before the fill of the table is checked.
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_used[i] && slot_source[i] == req) res.status = STAT_WAITING;
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      if (res.status == STAT_POSTED && (table_count >= table_limit || free_slot < 0))
        res.status = STAT_FULL;
      if (res.status == STAT_POSTED) begin
        for (int i = 0; i < SLOT_COUNT; i++)
          if (slot_used[i]) slot_rank[i]++;
        slot_used[free_slot]   = 1'b1;
        slot_source[free_slot] = req;
        slot_pos[free_slot]    = pos;
        slot_final[free_slot]  = fin;
        slot_rank[free_slot]   = 0;
        table_count++;
      end
    end else if (table_limit != 0 && table_count >= table_limit) begin
      // Nearest to the last served position; oldest entry wins a tie.
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_used[i]) begin
          gap = last_pos - int'(slot_pos[i]);
          if (gap < 0) gap = -gap;
          if (best < 0 || gap < best_gap ||
              (gap == best_gap && slot_rank[i] > slot_rank[best])) begin
            best     = i;
            best_gap = gap;
          end
        end
      end
      if (best >= 0) begin
        slot_used[best] = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (slot_used[i] && slot_rank[i] > slot_rank[best]) slot_rank[i]--;
        table_count--;
        last_pos = int'(slot_pos[best]);
        // A final request retires its source and may shrink the limit.
        if (slot_final[best] && live_sources > 0) live_sources--;
        if (live_sources < table_limit) table_limit = live_sources;
        res.status     = STAT_SERVED;
        res.requester  = slot_source[best];
        res.position   = slot_pos[best];
        res.final_mark = slot_final[best];
      end
    end
    res.occupancy = table_count[CFG_W-1:0];
    expected_results.insert(expected_results.size(), res);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, and the checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_request) begin
      stall_left    = HOLD_OFF_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, -1);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (served_requester_o !== want.requester)
          report_mismatch("served_requester", served_requester_o, want.requester);
        if (served_position_o !== want.position)
          report_mismatch("served_position", served_position_o, want.position);
        if (served_final_o !== want.final_mark)
          report_mismatch("served_final", served_final_o, want.final_mark);
        if (occupancy_o !== want.occupancy)
          report_mismatch("occupancy", occupancy_o, want.occupancy);
      end
    end
  end

  // Hang detector: any transfer on any port resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task below starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic mode, input logic [REQ_W-1:0] req,
                              input logic [POS_W-1:0] pos, input logic fin);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    mode_i          = mode;
    requester_i     = req;
    position_i      = pos;
    final_request_i = fin;
    in_valid_i      = 1'b1;
    // Hold the payload until the transfer happens.
    do @(posedge clk_i); while (!in_ready_o);
    predict_table_step(mode, req, pos, fin);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic index, input int value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {index, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (index == REG_CAPACITY) capacity_reg = value & 31;
    else source_count_reg = value & 31;
    reload_limits();
  endtask

  task automatic configure(input int cap, input int src);
    drain_results();
    write_register(REG_CAPACITY, cap);
    write_register(REG_SOURCE_COUNT, src);
  endtask

  // Bias positions toward small values and both ends so that distance ties
  // and extreme positions come up often.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(3))
      0: pick_position = POS_W'($urandom_range(7));
      1: pick_position = POS_W'(65535 - $urandom_range(7));
      default: pick_position = POS_W'($urandom());
    endcase
  endfunction

  // A source with no pending request, if one turns up quickly.
  function automatic logic [REQ_W-1:0] pick_idle_source();
    logic [REQ_W-1:0] cand;
    bit busy;
    cand = '0;
    for (int t = 0; t < 32; t++) begin
      cand = REQ_W'($urandom_range(15));
      busy = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_used[i] && slot_source[i] == cand) busy = 1'b1;
      if (!busy) return cand;
    end
    return cand;
  endfunction

  // Mostly well-formed traffic: fill to the limit, then serve; some noise.
  task automatic send_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15)
        send_request(logic'($urandom_range(1)), REQ_W'($urandom_range(15)),
                     pick_position(), logic'($urandom_range(1)));
      else if (table_count < table_limit)
        send_request(MODE_POST, pick_idle_source(), pick_position(),
                     logic'($urandom_range(99) < 8));
      else
        send_request(MODE_SERVE, REQ_W'($urandom_range(15)), POS_W'($urandom()),
                     logic'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every status, a waiting source at a full table, equal-position ties,
  // extreme positions and retirement of sources down to a zero limit.
  task automatic test_directed();
    configure(2, 4);
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // empty table: not ready
    send_request(MODE_POST, 4'd0, 16'd100, 1'b0);
    send_request(MODE_POST, 4'd0, 16'd5, 1'b0);       // source already waits
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // below limit: not ready
    send_request(MODE_POST, 4'd15, 16'd65535, 1'b1);
    send_request(MODE_POST, 4'd7, 16'd0, 1'b0);       // table full
    send_request(MODE_POST, 4'd15, 16'd1, 1'b0);      // waiting wins over full
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // nearest to -1
    send_request(MODE_POST, 4'd3, 16'd300, 1'b1);
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // retires a source
    send_request(MODE_POST, 4'd9, 16'd65535, 1'b1);   // same position as older entry
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // tie goes to the oldest
    send_request(MODE_POST, 4'd4, 16'd0, 1'b1);
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // limit shrank to one
    send_request(MODE_SERVE, 4'd0, 16'd0, 1'b0);      // zero limit: not ready
    send_request(MODE_POST, 4'd1, 16'd42, 1'b0);      // zero limit: full
  endtask

  task automatic test_register_extremes();
    configure(31, 31);   // capacity above the slot count saturates
    send_traffic(100);
    configure(0, 8);
    send_traffic(20);
    configure(8, 0);
    send_traffic(20);
    configure(1, 16);
    send_traffic(60);
  endtask

  task automatic test_random_settings();
    configure(16, 16);
    send_traffic(100);
    configure(4, 3);
    send_traffic(80);
    configure($urandom_range(1, 16), $urandom_range(1, 16));
    send_traffic(80);
    configure(16, 5);
    send_traffic(60);
  endtask

  task automatic test_back_to_back();
    configure(12, 16);
    quiet = 1'b1;
    send_traffic(100);
    quiet = 1'b0;
  endtask

  // Hold the result side off while requests keep coming, so the block fills
  // its output register and stops taking requests.
  task automatic test_backpressure();
    configure(16, 16);
    stall_request = 1'b1;
    send_traffic(40);
  endtask

  initial begin
    errors          = 0;
    quiet           = 1'b0;
    stall_request   = 1'b0;
    stall_left      = 0;
    idle_cycles     = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_POST;
    requester_i     = '0;
    position_i      = '0;
    final_request_i = 1'b0;
    out_ready_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    reset_table_shadow();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_settings();
    test_back_to_back();
    test_backpressure();

    drain_results();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### nearest_position_request_table.f
rtl/npr_pkg.sv
rtl/npr_ram.sv
rtl/nearest_position_request_table.sv
tb/sv/tb.sv
